@@ rtl/core/swoc_pkg.sv @@
// Shared constants, types and codes of the sliding-window ones counter.
package swoc_pkg;

  // Bucket list capacity and derived widths.
  localparam int unsigned MAX_BUCKETS = 32;
  localparam int unsigned SLOT_W      = $clog2(MAX_BUCKETS);
  localparam int unsigned TOT_W       = $clog2(MAX_BUCKETS + 1);

  // Field widths of the interface and of one bucket.
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned SIZE_W      = 5;
  localparam int unsigned STAMP_W     = 32;

  // Only the low bits of the window settings take part; the count saturates alike.
  localparam int unsigned WINDOW_BITS = 16;
  localparam int unsigned WIN_W       = (WINDOW_BITS < LEN_W) ? WINDOW_BITS : LEN_W;
  localparam int unsigned CNT_W       = (WINDOW_BITS < OUT_W) ? WINDOW_BITS : OUT_W;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_VALUE   = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } reg_e;

  // Item commands.
  typedef enum logic [0:0] {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // Sequencer states of the engine.
  typedef enum logic [3:0] {
    S_IDLE,
    S_C_HEAD,
    S_C_LOAD,
    S_C_SCAN,
    S_M_HEAD,
    S_M_MOVE,
    S_E_RD,
    S_E_CHK,
    S_Q_START,
    S_Q_WALK,
    S_Q_OUT
  } state_e;

  // One stored bucket: log2 of its size and the time of its newest item.
  typedef struct packed {
    logic [SIZE_W-1:0]  size_log;
    logic [STAMP_W-1:0] stamp;
  } bucket_t;

  // Item handed from the port side to the engine.
  typedef struct packed {
    logic                      valid;
    cmd_e                      command;
    logic signed [VALUE_W-1:0] item_value;
    logic [LEN_W-1:0]          query_window;
  } req_t;

  // Current configuration.
  typedef struct packed {
    logic signed [VALUE_W-1:0] match_value;
    logic [LEN_W-1:0]          window_length;
  } cfg_t;

  // Finished query count.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

@@ rtl/core/swoc_ram.sv @@
// Generic synchronous RAM with one write port and two registered read ports.
module swoc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/core/swoc_engine.sv @@
// Bucket list engine: circular bucket memory, merge cascade, expiry and query walk.
module swoc_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  swoc_pkg::req_t req_i,
  output logic           req_ready_o,
  input  swoc_pkg::cfg_t cfg_i,
  output swoc_pkg::res_t res_o,
  input  logic           res_ready_i
);
  import swoc_pkg::*;

  // Slot of a list position: base plus offset around the ring.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [TOT_W-1:0]  off);
    logic [TOT_W:0] s;
    s = (TOT_W + 1)'(base) + (TOT_W + 1)'(off);
    if (s >= (TOT_W + 1)'(MAX_BUCKETS)) begin
      s = s - (TOT_W + 1)'(MAX_BUCKETS);
    end
    return s[SLOT_W-1:0];
  endfunction

  // Source position of the m-th survivor while compacting: the newest bucket, then odd ones.
  function automatic logic [TOT_W-1:0] src_off(input logic [SLOT_W-1:0] m);
    logic [TOT_W-1:0] r;
    if (m == '0) begin
      r = '0;
    end else begin
      r = TOT_W'({m, 1'b0}) - TOT_W'(1);
    end
    return r;
  endfunction

  // Size log incremented with saturation.
  function automatic logic [SIZE_W-1:0] size_inc(input logic [SIZE_W-1:0] s);
    return (s == '1) ? s : s + SIZE_W'(1);
  endfunction

  state_e             state_q, state_d;
  logic [SLOT_W-1:0]  head_q, head_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [STAMP_W-1:0] clock_q, clock_d;
  logic [SIZE_W-1:0]  cur_q, cur_d;
  logic [TOT_W-1:0]   odd_q, odd_d;
  logic [SLOT_W-1:0]  k_q, k_d;
  logic [SLOT_W-1:0]  m_q, m_d;
  logic [WIN_W-1:0]   qwin_q, qwin_d;
  logic [CNT_W-1:0]   sum_q, sum_d;
  logic [TOT_W-1:0]   idx_q, idx_d;

  logic [SLOT_W-1:0]  ra_addr, rb_addr, waddr;
  logic               we;
  bucket_t            wdata, ra_data, rb_data;
  logic [$bits(bucket_t)-1:0] ra_rdata, rb_rdata;

  logic [WIN_W-1:0]   win;
  logic [WIN_W-1:0]   qreq;
  logic [STAMP_W-1:0] age;
  logic [CNT_W:0]     sum_ext;
  logic               sum_sat;
  logic [CNT_W-1:0]   sum_next;

  // Bucket store: newest bucket at head_q, older ones at rising slots.
  swoc_ram #(
    .WIDTH($bits(bucket_t)),
    .DEPTH(MAX_BUCKETS)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(ra_addr),
    .raddr_b_i(rb_addr),
    .rdata_a_o(ra_rdata),
    .rdata_b_o(rb_rdata)
  );

  assign ra_data = ra_rdata;
  assign rb_data = rb_rdata;

  // Window limits and age of the bucket on read port A.
  assign win  = cfg_i.window_length[WIN_W-1:0];
  assign qreq = req_i.query_window[WIN_W-1:0];
  assign age  = clock_q - ra_data.stamp;

  // Saturating add of one bucket size to the query sum.
  always_comb begin
    sum_ext  = {1'b0, sum_q} + ((CNT_W + 1)'(1) << ra_data.size_log);
    sum_sat  = (ra_data.size_log >= SIZE_W'(CNT_W)) || sum_ext[CNT_W];
    sum_next = sum_sat ? '1 : sum_ext[CNT_W-1:0];
  end

  // State and bucket list registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      total_q <= '0;
      clock_q <= '0;
      cur_q   <= '0;
      odd_q   <= '0;
      k_q     <= '0;
      m_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      total_q <= total_d;
      clock_q <= clock_d;
      cur_q   <= cur_d;
      odd_q   <= odd_d;
      k_q     <= k_d;
      m_q     <= m_d;
      idx_q   <= idx_d;
    end
  end

  // Query payload registers.
  always_ff @(posedge clk_i) begin
    qwin_q <= qwin_d;
    sum_q  <= sum_d;
  end

  // Sequencer: push, merge scan, compaction, expiry and query walk.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    total_d     = total_q;
    clock_d     = clock_q;
    cur_d       = cur_q;
    odd_d       = odd_q;
    k_d         = k_q;
    m_d         = m_q;
    qwin_d      = qwin_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    ra_addr     = head_q;
    rb_addr     = head_q;
    we          = 1'b0;
    waddr       = head_q;
    wdata       = '0;
    req_ready_o = 1'b0;
    res_o       = '0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_i.valid) begin
          if (req_i.command == CMD_QUERY) begin
            qwin_d  = (qreq > win) ? win : qreq;
            sum_d   = '0;
            state_d = S_Q_START;
          end else begin
            // A match pushes a size-one bucket; a full list loses its oldest slot.
            if (req_i.item_value == cfg_i.match_value) begin
              we             = 1'b1;
              waddr          = slot_add(head_q, TOT_W'(MAX_BUCKETS - 1));
              wdata.size_log = '0;
              wdata.stamp    = clock_q;
              head_d         = waddr;
              total_d        = (total_q == TOT_W'(MAX_BUCKETS)) ? total_q
                                                                : total_q + TOT_W'(1);
            end
            state_d = S_C_HEAD;
          end
        end
      end

      S_C_HEAD: begin
        k_d   = '0;
        odd_d = TOT_W'(1);
        if (total_q >= TOT_W'(3)) begin
          ra_addr = head_q;
          state_d = S_C_LOAD;
        end else begin
          state_d = S_E_RD;
        end
      end

      S_C_LOAD: begin
        cur_d   = ra_data.size_log;
        ra_addr = slot_add(head_q, odd_q);
        rb_addr = slot_add(head_q, odd_q + TOT_W'(1));
        state_d = S_C_SCAN;
      end

      // Ports hold the next two older buckets; cur_q is the bucket just before them.
      S_C_SCAN: begin
        if (cur_q == ra_data.size_log && ra_data.size_log == rb_data.size_log) begin
          k_d   = k_q + SLOT_W'(1);
          cur_d = size_inc(ra_data.size_log);
          odd_d = odd_q + TOT_W'(2);
          if ((TOT_W + 1)'(odd_q) + (TOT_W + 1)'(3) < (TOT_W + 1)'(total_q)) begin
            ra_addr = slot_add(head_q, odd_q + TOT_W'(2));
            rb_addr = slot_add(head_q, odd_q + TOT_W'(3));
          end else begin
            state_d = S_M_HEAD;
          end
        end else if (k_q == '0) begin
          state_d = S_E_RD;
        end else begin
          state_d = S_M_HEAD;
        end
      end

      S_M_HEAD: begin
        m_d     = k_q;
        ra_addr = slot_add(head_q, src_off(k_q));
        state_d = S_M_MOVE;
      end

      // Survivors move toward the old end, survivor m to slot k + m past the head, oldest survivor first.
      S_M_MOVE: begin
        we             = 1'b1;
        waddr          = slot_add(head_q, TOT_W'(k_q) + TOT_W'(m_q));
        wdata.stamp    = ra_data.stamp;
        wdata.size_log = (m_q != '0) ? size_inc(ra_data.size_log) : ra_data.size_log;
        if (m_q == '0) begin
          head_d  = slot_add(head_q, TOT_W'(k_q));
          total_d = total_q - TOT_W'(k_q);
          state_d = S_E_RD;
        end else begin
          m_d     = m_q - SLOT_W'(1);
          ra_addr = slot_add(head_q, src_off(m_q - SLOT_W'(1)));
        end
      end

      S_E_RD: begin
        if (total_q == '0) begin
          clock_d = clock_q + STAMP_W'(1);
          state_d = S_IDLE;
        end else begin
          ra_addr = slot_add(head_q, total_q - TOT_W'(1));
          state_d = S_E_CHK;
        end
      end

      S_E_CHK: begin
        if (age >= STAMP_W'(win)) begin
          total_d = total_q - TOT_W'(1);
        end
        clock_d = clock_q + STAMP_W'(1);
        state_d = S_IDLE;
      end

      S_Q_START: begin
        idx_d = TOT_W'(1);
        if (total_q == '0) begin
          state_d = S_Q_OUT;
        end else begin
          ra_addr = head_q;
          state_d = S_Q_WALK;
        end
      end

      // Port A holds the bucket at position idx_q - 1.
      S_Q_WALK: begin
        if (age > STAMP_W'(qwin_q)) begin
          state_d = S_Q_OUT;
        end else begin
          sum_d = sum_next;
          if (idx_q == total_q) begin
            state_d = S_Q_OUT;
          end else begin
            ra_addr = slot_add(head_q, idx_q);
            idx_d   = idx_q + TOT_W'(1);
          end
        end
      end

      S_Q_OUT: begin
        res_o.valid = 1'b1;
        res_o.count = sum_q;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Compaction never reads a slot in the same cycle that it overwrites it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M_MOVE && m_q != '0) |-> (waddr != ra_addr))
    else $error("compaction read and write hit the same slot");

  // Every merge consumed two buckets beyond the newest one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M_MOVE) |-> ((SLOT_W + 2)'({k_q, 1'b1}) <= (SLOT_W + 2)'(total_q)))
    else $error("merge count exceeds the bucket list");

  // An add item advances time by exactly one when its expiry check finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_E_CHK) |=> (clock_q == $past(clock_q) + STAMP_W'(1)))
    else $error("item time did not advance after an add");
`endif

endmodule

@@ rtl/core/sliding_window_ones_counter_core.sv @@
// Top level of the sliding-window ones counter: ports, configuration and result register.
// Add item: its time is set by the merge scan and the compaction, with k merges, k at most 15.
// Query item: its time is set by the walk over the bucket memory; the result then waits in
//   an output register while adds proceed.
// One item is in work at a time. Reset clears the bucket count, the item time and the
//   configuration (match 1, window 1024) at once; the bucket memory is not cleared.
module sliding_window_ones_counter_core (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [swoc_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [swoc_pkg::LEN_W-1:0]                cfg_wdata_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic                                      command_i,
  input  logic signed [swoc_pkg::VALUE_W-1:0]       item_value_i,
  input  logic [swoc_pkg::LEN_W-1:0]                query_window_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [swoc_pkg::OUT_W-1:0]                window_count_o
);
  import swoc_pkg::*;

  cfg_t             cfg_q;
  req_t             req;
  res_t             res;
  logic             res_ready;
  logic             out_valid_q;
  logic [OUT_W-1:0] window_count_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_value   <= VALUE_W'(1);
      cfg_q.window_length <= LEN_W'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MATCH_VALUE:   cfg_q.match_value   <= cfg_wdata_i;
        REG_WINDOW_LENGTH: cfg_q.window_length <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Incoming item.
  always_comb begin
    req.valid        = in_valid_i;
    req.command      = cmd_e'(command_i);
    req.item_value   = item_value_i;
    req.query_window = query_window_i;
  end

  swoc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .req_ready_o(in_ready_o),
    .cfg_i      (cfg_q),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  // Result register: takes a new count once the previous one has left.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      window_count_q <= OUT_W'(res.count);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_count_o = window_count_q;

endmodule
